// ===== hdl/hub75_frame_store_and_scan_top_defines.svh =====
// Assertion macros shared by the checker modules of the frame store block.
`ifndef HUB75_FRAME_STORE_AND_SCAN_TOP_DEFINES_SVH
`define HUB75_FRAME_STORE_AND_SCAN_TOP_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define HFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The consequent must hold a fixed number of edges after the antecedent.
`define HFS_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
	else $error(msg);

`endif

// ===== hdl/hfs_pkg.sv =====
package hfs_pkg;

	localparam int PANEL_WIDTH_DEF  = 64;
	localparam int PANEL_HEIGHT_DEF = 64;
	localparam int SCAN_ROWS_DEF    = 32;

	localparam int COLOR_W      = 3;
	localparam int COORD_W      = 8;
	localparam int ROW_CNT_W    = COORD_W + 1;
	localparam int ADDR_LINES_W = 5;
	localparam int CMD_W        = 3;
	localparam int BORDER_SIDES = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCAN   = 3'd0,
		CMD_PIXEL  = 3'd1,
		CMD_FILL   = 3'd2,
		CMD_BORDER = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		BOX_PIXEL,
		BOX_FILL,
		BOX_TOP,
		BOX_BOTTOM,
		BOX_LEFT,
		BOX_RIGHT,
		BOX_ALL,
		BOX_WIPE
	} box_sel_t;

	typedef struct packed {
		logic     capture;
		logic     box_load;
		box_sel_t box_sel;
		logic     row_write;
		logic     scan_read;
		logic     scan_send;
	} dp_ctrl_t;

	typedef struct packed {
		logic rows_more;
	} dp_status_t;

endpackage

// ===== hdl/hfs_ctrl.sv =====
module hfs_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [hfs_pkg::CMD_W-1:0] cmd,
	output logic                     busy,
	output hfs_pkg::dp_ctrl_t        ctrl,
	input  hfs_pkg::dp_status_t      status
);

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_LOAD  = 6'b000100,
		S_WRITE = 6'b001000,
		S_READ  = 6'b010000,
		S_SEND  = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic [hfs_pkg::CMD_W-1:0]   cmd_q, cmd_d;
	logic [1:0]                  side_q, side_d;
	logic                        accept;
	hfs_pkg::box_sel_t           sel;

	assign busy   = !(state_q == S_IDLE || state_q == S_SEND);
	assign accept = start && !busy;

	always_comb begin
		case (cmd_q)
			hfs_pkg::CMD_PIXEL: sel = hfs_pkg::BOX_PIXEL;
			hfs_pkg::CMD_CLEAR: sel = hfs_pkg::BOX_ALL;
			hfs_pkg::CMD_BORDER: begin
				case (side_q)
					2'd0:    sel = hfs_pkg::BOX_TOP;
					2'd1:    sel = hfs_pkg::BOX_BOTTOM;
					2'd2:    sel = hfs_pkg::BOX_LEFT;
					default: sel = hfs_pkg::BOX_RIGHT;
				endcase
			end
			default: sel = hfs_pkg::BOX_FILL;
		endcase
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		side_d  = side_q;
		ctrl    = '0;
		ctrl.box_sel = sel;
		case (state_q)
			S_INIT: begin
				ctrl.box_load = 1'b1;
				ctrl.box_sel  = hfs_pkg::BOX_WIPE;
				state_d       = S_WRITE;
			end
			S_LOAD: begin
				ctrl.box_load = 1'b1;
				state_d       = S_WRITE;
			end
			S_WRITE: begin
				ctrl.row_write = 1'b1;
				if (!status.rows_more) begin
					if (cmd_q == hfs_pkg::CMD_BORDER &&
					    side_q != 2'(hfs_pkg::BORDER_SIDES - 1)) begin
						side_d  = side_q + 2'd1;
						state_d = S_LOAD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_READ: begin
				ctrl.scan_read = 1'b1;
				state_d        = S_SEND;
			end
			S_SEND: begin
				ctrl.scan_send = 1'b1;
				state_d        = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (accept) begin
			ctrl.capture = 1'b1;
			cmd_d        = cmd;
			side_d       = 2'd0;
			case (cmd)
				hfs_pkg::CMD_SCAN:   state_d = S_READ;
				hfs_pkg::CMD_PIXEL,
				hfs_pkg::CMD_FILL,
				hfs_pkg::CMD_BORDER,
				hfs_pkg::CMD_CLEAR:  state_d = S_LOAD;
				default:             state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cmd_q   <= hfs_pkg::CMD_SCAN;
			side_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
			side_q  <= side_d;
		end
	end

endmodule

// ===== hdl/hfs_datapath.sv =====
module hfs_datapath #(
	parameter int PANEL_WIDTH  = hfs_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = hfs_pkg::PANEL_HEIGHT_DEF,
	parameter int SCAN_ROWS    = hfs_pkg::SCAN_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hfs_pkg::dp_ctrl_t                ctrl,
	output hfs_pkg::dp_status_t              status,
	input  logic [hfs_pkg::COORD_W-1:0]      pos_x,
	input  logic [hfs_pkg::COORD_W-1:0]      pos_y,
	input  logic [hfs_pkg::COORD_W-1:0]      rect_width,
	input  logic [hfs_pkg::COORD_W-1:0]      rect_height,
	input  logic [hfs_pkg::COORD_W-1:0]      border_thickness,
	input  logic [hfs_pkg::COLOR_W-1:0]      pixel_color,
	output logic                             result_strobe,
	output logic [hfs_pkg::COLOR_W-1:0]      top_rgb,
	output logic [hfs_pkg::COLOR_W-1:0]      bottom_rgb,
	output logic                             shift_clock,
	output logic                             latch_pulse,
	output logic [hfs_pkg::ADDR_LINES_W-1:0] row_address,
	output logic                             output_enable_n,
	output logic                             frame_done
);

	localparam int CLR_W    = hfs_pkg::COLOR_W;
	localparam int CRD_W    = hfs_pkg::COORD_W;
	localparam int RCW      = hfs_pkg::ROW_CNT_W;
	localparam int ALW      = hfs_pkg::ADDR_LINES_W;
	localparam int AW       = $clog2(PANEL_HEIGHT);
	localparam int CW       = $clog2(PANEL_WIDTH);
	localparam int SCW      = $clog2(PANEL_WIDTH + 1);
	localparam int SRW      = $clog2(SCAN_ROWS);
	localparam int ROW_BITS = PANEL_WIDTH * CLR_W;
	localparam logic [RCW-1:0] W_LIM  = RCW'(PANEL_WIDTH);
	localparam logic [RCW-1:0] H_LIM  = RCW'(PANEL_HEIGHT);
	localparam logic [RCW-1:0] SR_LIM = RCW'(SCAN_ROWS);

	logic [CRD_W-1:0]       x_q, y_q, w_q, h_q, t_q;
	logic [CLR_W-1:0]       color_q;

	logic [CRD_W-1:0]       bx, by, bw, bh;
	logic                   full;
	logic [RCW-1:0]         xe_sum, ye_sum, xe_clip, ye_clip;
	logic [PANEL_WIDTH-1:0] box_mask;

	logic [PANEL_WIDTH-1:0] mask_q;
	logic [RCW-1:0]         row_q, row_end_q;
	logic [CLR_W-1:0]       wcolor_q;
	logic                   row_we;

	logic [ROW_BITS-1:0]    mem_q [PANEL_HEIGHT];
	logic [ROW_BITS-1:0]    top_row_s1, bot_row_s1;
	logic                   top_ok_s1, bot_ok_s1;
	logic [RCW-1:0]         top_line, bot_line;

	logic [SRW-1:0]         scan_row_q;
	logic [SCW-1:0]         scan_col_q;
	logic [ALW-1:0]         addr_q;
	logic                   oen_lvl_q;
	logic [CLR_W-1:0]       held_top_q, held_bot_q;
	logic                   strobe_q;

	logic [CW-1:0]          col_idx;
	logic [CLR_W-1:0]       pix_top, pix_bot;
	logic                   shifting, row_last;

	logic [CLR_W-1:0]       top_rgb_q, bottom_rgb_q;
	logic                   shift_q, latch_q, done_q, oen_q;
	logic [ALW-1:0]         raddr_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			w_q     <= rect_width;
			h_q     <= rect_height;
			t_q     <= border_thickness;
			color_q <= pixel_color;
		end
	end

	always_comb begin
		full = 1'b0;
		bx   = x_q;
		by   = y_q;
		bw   = w_q;
		bh   = h_q;
		case (ctrl.box_sel)
			hfs_pkg::BOX_PIXEL: begin
				bw = CRD_W'(1);
				bh = CRD_W'(1);
			end
			hfs_pkg::BOX_FILL: ;
			hfs_pkg::BOX_TOP: bh = t_q;
			hfs_pkg::BOX_BOTTOM: begin
				by = y_q + h_q - t_q;
				bh = t_q;
			end
			hfs_pkg::BOX_LEFT: bw = t_q;
			hfs_pkg::BOX_RIGHT: begin
				bx = x_q + w_q - t_q;
				bw = t_q;
			end
			default: full = 1'b1;
		endcase
		xe_sum  = {1'b0, bx} + {1'b0, bw};
		ye_sum  = {1'b0, by} + {1'b0, bh};
		xe_clip = (xe_sum > W_LIM) ? W_LIM : xe_sum;
		ye_clip = (ye_sum > H_LIM) ? H_LIM : ye_sum;
		for (int i = 0; i < PANEL_WIDTH; i++) begin
			box_mask[i] = full || ((RCW'(i) >= {1'b0, bx}) && (RCW'(i) < xe_clip));
		end
	end

	assign row_we           = ctrl.row_write && (row_q < row_end_q);
	assign status.rows_more = (row_q + RCW'(1)) < row_end_q;

	always_ff @(posedge clk) begin
		if (ctrl.box_load) begin
			mask_q    <= box_mask;
			row_q     <= full ? '0 : {1'b0, by};
			row_end_q <= full ? H_LIM : ye_clip;
			wcolor_q  <= (ctrl.box_sel == hfs_pkg::BOX_WIPE) ? '0 : color_q;
		end else if (row_we) begin
			row_q <= row_q + RCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			for (int i = 0; i < PANEL_WIDTH; i++) begin
				if (mask_q[i]) begin
					mem_q[row_q[AW-1:0]][i*CLR_W +: CLR_W] <= wcolor_q;
				end
			end
		end
	end

	assign top_line = RCW'(scan_row_q);
	assign bot_line = RCW'(scan_row_q) + SR_LIM;

	always_ff @(posedge clk) begin
		if (ctrl.scan_read) begin
			top_row_s1 <= mem_q[top_line[AW-1:0]];
			bot_row_s1 <= mem_q[bot_line[AW-1:0]];
			top_ok_s1  <= top_line < H_LIM;
			bot_ok_s1  <= bot_line < H_LIM;
		end
	end

	assign col_idx  = scan_col_q[CW-1:0];
	assign pix_top  = top_ok_s1 ? top_row_s1[col_idx*CLR_W +: CLR_W] : '0;
	assign pix_bot  = bot_ok_s1 ? bot_row_s1[col_idx*CLR_W +: CLR_W] : '0;
	assign shifting = scan_col_q < SCW'(PANEL_WIDTH);
	assign row_last = (top_line + RCW'(1)) >= SR_LIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			scan_col_q <= '0;
			addr_q     <= '0;
			oen_lvl_q  <= 1'b1;
			held_top_q <= '0;
			held_bot_q <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= ctrl.scan_send;
			if (ctrl.scan_send) begin
				if (shifting) begin
					held_top_q <= pix_top;
					held_bot_q <= pix_bot;
					scan_col_q <= scan_col_q + SCW'(1);
				end else begin
					addr_q     <= top_line[ALW-1:0];
					oen_lvl_q  <= 1'b0;
					scan_col_q <= '0;
					scan_row_q <= row_last ? '0 : scan_row_q + SRW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_send) begin
			if (shifting) begin
				top_rgb_q    <= pix_top;
				bottom_rgb_q <= pix_bot;
				shift_q      <= 1'b1;
				latch_q      <= 1'b0;
				raddr_q      <= addr_q;
				oen_q        <= oen_lvl_q;
				done_q       <= 1'b0;
			end else begin
				top_rgb_q    <= held_top_q;
				bottom_rgb_q <= held_bot_q;
				shift_q      <= 1'b0;
				latch_q      <= 1'b1;
				raddr_q      <= top_line[ALW-1:0];
				oen_q        <= 1'b1;
				done_q       <= row_last;
			end
		end
	end

	assign result_strobe   = strobe_q;
	assign top_rgb         = top_rgb_q;
	assign bottom_rgb      = bottom_rgb_q;
	assign shift_clock     = shift_q;
	assign latch_pulse     = latch_q;
	assign row_address     = raddr_q;
	assign output_enable_n = oen_q;
	assign frame_done      = done_q;

endmodule

// ===== hdl/hub75_frame_store_and_scan_top.sv =====
// A scan tick is accepted with start; its read step, send step and output register lie between
// it and its word on result_strobe. busy drops in the send step, so a new scan tick can be taken
// before the last word is out. Set pixel keeps busy for a load and a write step, a fill for a load
// and a write step per clipped row (at least one), a border for four such fills, and clear for a
// load and PANEL_HEIGHT rows, one row per cycle. After reset busy stays high while the frame store
// is wiped. The receiver cannot stall, so every word is taken in the cycle its strobe is high.
module hub75_frame_store_and_scan_top #(
	parameter int PANEL_WIDTH  = hfs_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = hfs_pkg::PANEL_HEIGHT_DEF,
	parameter int SCAN_ROWS    = hfs_pkg::SCAN_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [hfs_pkg::CMD_W-1:0]        cmd,
	input  logic [hfs_pkg::COORD_W-1:0]      pos_x,
	input  logic [hfs_pkg::COORD_W-1:0]      pos_y,
	input  logic [hfs_pkg::COORD_W-1:0]      rect_width,
	input  logic [hfs_pkg::COORD_W-1:0]      rect_height,
	input  logic [hfs_pkg::COORD_W-1:0]      border_thickness,
	input  logic [hfs_pkg::COLOR_W-1:0]      pixel_color,
	output logic                             result_strobe,
	output logic [hfs_pkg::COLOR_W-1:0]      top_rgb,
	output logic [hfs_pkg::COLOR_W-1:0]      bottom_rgb,
	output logic                             shift_clock,
	output logic                             latch_pulse,
	output logic [hfs_pkg::ADDR_LINES_W-1:0] row_address,
	output logic                             output_enable_n,
	output logic                             frame_done
);

	hfs_pkg::dp_ctrl_t   ctrl;
	hfs_pkg::dp_status_t status;

	hfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctrl   (ctrl),
		.status (status)
	);

	hfs_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.SCAN_ROWS    (SCAN_ROWS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.status           (status),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.rect_width       (rect_width),
		.rect_height      (rect_height),
		.border_thickness (border_thickness),
		.pixel_color      (pixel_color),
		.result_strobe    (result_strobe),
		.top_rgb          (top_rgb),
		.bottom_rgb       (bottom_rgb),
		.shift_clock      (shift_clock),
		.latch_pulse      (latch_pulse),
		.row_address      (row_address),
		.output_enable_n  (output_enable_n),
		.frame_done       (frame_done)
	);

endmodule

// ===== hdl/hfs_checker.sv =====
`include "hub75_frame_store_and_scan_top_defines.svh"

module hfs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [hfs_pkg::CMD_W-1:0] cmd,
	input logic                      result_strobe,
	input logic                      shift_clock,
	input logic                      latch_pulse,
	input logic                      output_enable_n,
	input logic                      frame_done
);

	`HFS_ASSERT_DELAY(a_scan_gives_word, start && !busy && cmd == hfs_pkg::CMD_SCAN, 3, result_strobe, "scan tick did not produce a word")
	`HFS_ASSERT_NOW(a_word_from_scan, result_strobe, $past(start && !busy && cmd == hfs_pkg::CMD_SCAN, 3), "word without a scan tick")
	`HFS_ASSERT_NOW(a_latch_blanks, result_strobe && latch_pulse, output_enable_n && !shift_clock, "latch step not blanked")
	`HFS_ASSERT_NOW(a_done_on_latch, result_strobe && frame_done, latch_pulse, "frame done outside a latch step")

endmodule

bind hub75_frame_store_and_scan_top hfs_checker u_hfs_checker (.*);

// ===== bench/hub75_frame_store_and_scan_top_tb.sv =====
module hub75_frame_store_and_scan_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hfs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = BORDER_SIDES * (PANEL_HEIGHT_DEF + 1) + 8;
	localparam int STORE_DEPTH = PANEL_WIDTH_DEF * PANEL_HEIGHT_DEF;
	localparam int NUM_DIRECTED = 25;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [COORD_W-1:0] t;
		logic [COLOR_W-1:0] color;
	} panel_word_t;

	typedef struct packed {
		logic [COLOR_W-1:0]      top;
		logic [COLOR_W-1:0]      bottom;
		logic                    sclk;
		logic                    latch;
		logic [ADDR_LINES_W-1:0] addr;
		logic                    oen;
		logic                    fdone;
	} scan_word_t;

	typedef struct packed {
		panel_word_t item;
		logic        typed;
		scan_word_t  want;
	} stim_row_t;

	localparam scan_word_t NO_WANT = '0;

	localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{'{CMD_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b1,
			'{3'd0, 3'd0, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0}},
		'{'{CMD_PIXEL, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 3'd5}, 1'b0, NO_WANT},
		'{'{CMD_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b1,
			'{3'd5, 3'd0, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0}},
		'{'{CMD_PIXEL, 8'd2, 8'd32, 8'd0, 8'd0, 8'd0, 3'd3}, 1'b0, NO_WANT},
		'{'{CMD_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b1,
			'{3'd0, 3'd3, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0}},
		'{'{CMD_PIXEL, 8'd64, 8'd0, 8'd0, 8'd0, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_FILL, 8'd60, 8'd0, 8'd255, 8'd255, 8'd0, 3'd6}, 1'b0, NO_WANT},
		'{'{CMD_FILL, 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_FILL, 8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_FILL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_BORDER, 8'd10, 8'd10, 8'd20, 8'd20, 8'd2, 3'd1}, 1'b0, NO_WANT},
		'{'{CMD_BORDER, 8'd0, 8'd0, 8'd3, 8'd3, 8'd200, 3'd2}, 1'b0, NO_WANT},
		'{'{CMD_BORDER, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_BORDER, 8'd0, 8'd0, 8'd64, 8'd64, 8'd0, 3'd4}, 1'b0, NO_WANT},
		'{'{CMD_UNUSED_LO, 8'd0, 8'd0, 8'd64, 8'd64, 8'd0, 3'd4}, 1'b0, NO_WANT},
		'{'{CMD_UNUSED_LO + 3'd1, 8'd0, 8'd0, 8'd8, 8'd8, 8'd1, 3'd1}, 1'b0, NO_WANT},
		'{'{CMD_UNUSED_HI, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_SCAN, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd7}, 1'b0, NO_WANT},
		'{'{CMD_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b1,
			'{3'd7, 3'd7, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0}},
		'{'{CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b0, NO_WANT},
		'{'{CMD_SCAN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0}, 1'b1,
			'{3'd0, 3'd0, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0}},
		'{'{CMD_FILL, 8'd0, 8'd0, 8'd64, 8'd64, 8'd0, 3'd5}, 1'b0, NO_WANT}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [CMD_W-1:0]        cmd;
	logic [COORD_W-1:0]      pos_x;
	logic [COORD_W-1:0]      pos_y;
	logic [COORD_W-1:0]      rect_width;
	logic [COORD_W-1:0]      rect_height;
	logic [COORD_W-1:0]      border_thickness;
	logic [COLOR_W-1:0]      pixel_color;
	logic                    result_strobe;
	logic [COLOR_W-1:0]      top_rgb;
	logic [COLOR_W-1:0]      bottom_rgb;
	logic                    shift_clock;
	logic                    latch_pulse;
	logic [ADDR_LINES_W-1:0] row_address;
	logic                    output_enable_n;
	logic                    frame_done;

	logic [COLOR_W-1:0]      canvas [STORE_DEPTH];
	int                      scan_line;
	int                      scan_col;
	logic [ADDR_LINES_W-1:0] drive_addr;
	logic                    blank_level;
	logic [COLOR_W-1:0]      last_top;
	logic [COLOR_W-1:0]      last_bottom;

	scan_word_t pending_scans [$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         idle_pct;
	int         idle_plan [3] = '{35, 58, 0};

	hub75_frame_store_and_scan_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.border_thickness(border_thickness),
		.pixel_color(pixel_color),
		.result_strobe(result_strobe),
		.top_rgb(top_rgb),
		.bottom_rgb(bottom_rgb),
		.shift_clock(shift_clock),
		.latch_pulse(latch_pulse),
		.row_address(row_address),
		.output_enable_n(output_enable_n),
		.frame_done(frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void reset_panel_model();
		foreach (canvas[i]) canvas[i] = '0;
		scan_line = 0;
		scan_col = 0;
		drive_addr = '0;
		blank_level = 1'b1;
		last_top = '0;
		last_bottom = '0;
	endfunction

	function automatic logic [COLOR_W-1:0] stored_color(int x, int y);
		if (x >= PANEL_WIDTH_DEF || y >= PANEL_HEIGHT_DEF)
			return '0;
		return canvas[y * PANEL_WIDTH_DEF + x];
	endfunction

	function automatic void paint_box(int x, int y, int w, int h, logic [COLOR_W-1:0] c);
		int xe;
		int ye;
		xe = (x + w > PANEL_WIDTH_DEF) ? PANEL_WIDTH_DEF : x + w;
		ye = (y + h > PANEL_HEIGHT_DEF) ? PANEL_HEIGHT_DEF : y + h;
		for (int j = y; j < ye; j++)
			for (int i = x; i < xe; i++)
				canvas[j * PANEL_WIDTH_DEF + i] = c;
	endfunction

	function automatic void apply_drawing(panel_word_t it);
		int x;
		int y;
		int w;
		int h;
		int t;
		x = int'(it.x);
		y = int'(it.y);
		w = int'(it.w);
		h = int'(it.h);
		t = int'(it.t);
		case (it.op)
			CMD_PIXEL: begin
				if (x < PANEL_WIDTH_DEF && y < PANEL_HEIGHT_DEF)
					canvas[y * PANEL_WIDTH_DEF + x] = it.color;
			end
			CMD_FILL: paint_box(x, y, w, h, it.color);
			CMD_BORDER: begin
				paint_box(x, y, w, t, it.color);
				paint_box(x, (y + h - t) & 'hFF, w, t, it.color);
				paint_box(x, y, t, h, it.color);
				paint_box((x + w - t) & 'hFF, y, t, h, it.color);
			end
			CMD_CLEAR: foreach (canvas[i]) canvas[i] = it.color;
			default: ;
		endcase
	endfunction

	function automatic scan_word_t advance_scan();
		scan_word_t w;
		logic       last_row;
		if (scan_col < PANEL_WIDTH_DEF) begin
			last_top = stored_color(scan_col, scan_line);
			last_bottom = stored_color(scan_col, scan_line + SCAN_ROWS_DEF);
			w = '{last_top, last_bottom, 1'b1, 1'b0, drive_addr, blank_level, 1'b0};
			scan_col++;
		end else begin
			last_row = (scan_line + 1 >= SCAN_ROWS_DEF);
			drive_addr = ADDR_LINES_W'(scan_line);
			blank_level = 1'b0;
			w = '{last_top, last_bottom, 1'b0, 1'b1, drive_addr, 1'b1, last_row};
			scan_col = 0;
			scan_line = last_row ? 0 : scan_line + 1;
		end
		return w;
	endfunction

	function automatic panel_word_t random_item();
		panel_word_t it;
		int          r;
		bit          wide;
		r = $urandom_range(99);
		wide = 1'($urandom_range(1));
		it.x = COORD_W'(wide ? $urandom_range(255) : $urandom_range(PANEL_WIDTH_DEF - 1));
		it.y = COORD_W'(wide ? $urandom_range(255) : $urandom_range(PANEL_HEIGHT_DEF - 1));
		it.w = COORD_W'(wide ? $urandom_range(255) : $urandom_range(16));
		it.h = COORD_W'(wide ? $urandom_range(255) : $urandom_range(16));
		it.t = COORD_W'(wide ? $urandom_range(255) : $urandom_range(4));
		it.color = COLOR_W'($urandom_range(7));
		if (r < 3)
			it.op = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		else if (r < 83)
			it.op = CMD_SCAN;
		else if (r < 91)
			it.op = CMD_PIXEL;
		else if (r < 96)
			it.op = CMD_FILL;
		else if (r < 99)
			it.op = CMD_BORDER;
		else
			it.op = CMD_CLEAR;
		return it;
	endfunction

	task automatic issue_word(input panel_word_t it, input logic typed, input scan_word_t want);
		scan_word_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= CMD_W'($urandom);
			pos_x <= COORD_W'($urandom);
			pos_y <= COORD_W'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= it.op;
		pos_x <= it.x;
		pos_y <= it.y;
		rect_width <= it.w;
		rect_height <= it.h;
		border_thickness <= it.t;
		pixel_color <= it.color;
		do @(posedge clk); while (busy);
		if (it.op == CMD_SCAN) begin
			predicted = advance_scan();
			pending_scans.push_back(typed ? want : predicted);
		end else begin
			apply_drawing(it);
		end
	endtask

	function automatic void compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		scan_word_t want;
		if (arst_n && result_strobe) begin
			if (pending_scans.size() == 0) begin
				$error("scan word arrived with no prediction waiting");
				mismatches++;
			end else begin
				want = pending_scans.pop_front();
				compare_field("top_rgb", int'(want.top), int'(top_rgb));
				compare_field("bottom_rgb", int'(want.bottom), int'(bottom_rgb));
				compare_field("shift_clock", int'(want.sclk), int'(shift_clock));
				compare_field("latch_pulse", int'(want.latch), int'(latch_pulse));
				compare_field("row_address", int'(want.addr), int'(row_address));
				compare_field("output_enable_n", int'(want.oen), int'(output_enable_n));
				compare_field("frame_done", int'(want.fdone), int'(frame_done));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		panel_word_t it;
		int          counted;
		idle_pct = idle_plan[0];
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_SCAN;
		pos_x = '0;
		pos_y = '0;
		rect_width = '0;
		rect_height = '0;
		border_thickness = '0;
		pixel_color = '0;
		reset_panel_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			issue_word(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				it = random_item();
				issue_word(it, 1'b0, NO_WANT);
				if (it.op <= CMD_CLEAR)
					counted++;
			end
		end
		start <= 1'b0;

		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
